// ----- src/sfa_pkg.sv -----
package sfa_pkg;

    localparam int CLASS_COUNT  = 24;
    localparam int CLASS_DEPTH  = 64;
    localparam int ADDR_BITS    = 32;
    localparam int HEADER_BYTES = 16;
    localparam int BIG_HEADERS  = 30;

    localparam int CLASS_BITS = $clog2(CLASS_COUNT);
    localparam int DEPTH_BITS = $clog2(CLASS_DEPTH);
    localparam int COUNT_BITS = $clog2(CLASS_DEPTH + 1);
    localparam int MEM_DEPTH  = CLASS_COUNT * CLASS_DEPTH;
    localparam int MEM_BITS   = $clog2(MEM_DEPTH);
    localparam int LAST_CLASS = CLASS_COUNT - 1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    // Bytes of class k; sizes past the table step by 8192.
    function automatic logic [31:0] class_bytes(input int k);
        logic [31:0] r;
        case (k)
            0:  r = 32'd4;
            1:  r = 32'd16;
            2:  r = 32'd32;
            3:  r = 32'd64;
            4:  r = 32'd128;
            5:  r = 32'd256;
            6:  r = 32'd512;
            7:  r = 32'd1024;
            8:  r = 32'd2048;
            9:  r = 32'd4096;
            10: r = 32'd8192;
            11: r = 32'd16384;
            default: r = 32'(32768 + (k - 12) * 8192);
        endcase
        return r;
    endfunction

endpackage

// ----- src/sfa_if.sv -----
interface sfa_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] request_size;
    logic [31:0] block_address;
    modport source (output valid, mode, request_size, block_address, input ready);
    modport sink (input valid, mode, request_size, block_address, output ready);
endinterface

interface sfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_address;
    logic [31:0] granted_size;
    logic [1:0]  status;
    modport source (output valid, payload_address, granted_size, status, input ready);
    modport sink (input valid, payload_address, granted_size, status, output ready);
endinterface

interface sfa_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/segregated_fit_allocator.sv -----
// Channel | Dir | Payload
// req     | in  | mode, request_size, block_address
// rsp     | out | payload_address, granted_size, status
// cfg     | in  | index (0 heap_base, 1 heap_limit), data
//
// Free: accept, count lookup and address memory write, result.
// Small-class alloc: accept, count lookup, address memory read or carve,
// result. Largest-class alloc: accept, count lookup and result, plus a read
// and a compare per stored entry walked, plus a read and a write per entry
// above a hit moved down to close the gap; a miss ends in a carve. The
// address and size memories are single-port. rst_n clears counts and heap
// pointer at once. A result held by rsp.ready blocks the next request only
// until the output register is taken.
module segregated_fit_allocator (
    input  logic clk,
    input  logic rst_n,
    sfa_req_if.sink   req,
    sfa_rsp_if.source rsp,
    sfa_cfg_if.sink   cfg
);
    localparam int AB = sfa_pkg::ADDR_BITS;
    localparam int CB = sfa_pkg::CLASS_BITS;
    localparam int DB = sfa_pkg::DEPTH_BITS;
    localparam int NB = sfa_pkg::COUNT_BITS;
    localparam int MB = sfa_pkg::MEM_BITS;
    localparam logic [CB-1:0] LAST = CB'(sfa_pkg::LAST_CLASS);
    localparam logic [NB-1:0] DEPTH_N = NB'(sfa_pkg::CLASS_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_READ, S_POP, S_SCAN, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR
    } state_t;

    state_t           state_reg;
    logic             mode_reg;
    logic [31:0]      size_reg;
    logic [31:0]      baddr_reg;
    logic [CB-1:0]    cls_reg;
    logic [NB-1:0]    n_reg;
    logic [DB-1:0]    k_reg;
    logic [AB-1:0]    hit_addr_reg;
    logic [31:0]      hit_size_reg;
    logic [AB-1:0]    top_reg;
    logic [31:0]      limit_reg;
    logic [NB-1:0]    count_reg [sfa_pkg::CLASS_COUNT];

    logic             rsp_valid_reg;
    logic [31:0]      rsp_addr_reg;
    logic [31:0]      rsp_size_reg;
    logic [1:0]       rsp_status_reg;

    // Address memory (all classes) and size memory of the largest class.
    logic [AB-1:0]    addr_mem [sfa_pkg::MEM_DEPTH];
    logic [31:0]      size_mem [sfa_pkg::CLASS_DEPTH];
    logic [AB-1:0]    addr_q;
    logic [31:0]      size_q;
    logic             mem_rd;
    logic             mem_wr;
    logic [DB-1:0]    mem_slot;
    logic [AB-1:0]    wr_addr_data;
    logic [31:0]      wr_size_data;
    logic             wr_size_en;
    logic [MB-1:0]    mem_index;

    assign mem_index = MB'(cls_reg) * MB'(sfa_pkg::CLASS_DEPTH) + MB'(mem_slot);

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            addr_mem[mem_index] <= wr_addr_data;
            if (wr_size_en)
                size_mem[mem_slot] <= wr_size_data;
        end
        else if (mem_rd)
        begin
            addr_q <= addr_mem[mem_index];
            size_q <= size_mem[mem_slot];
        end
    end

    // Class lookup: count the class sizes below the last that the size exceeds.
    logic [CB-1:0] req_cls;
    always_comb
    begin
        req_cls = '0;
        for (int k = 0; k < sfa_pkg::LAST_CLASS; k++)
            if (req.request_size > sfa_pkg::class_bytes(k))
                req_cls = req_cls + CB'(1);
    end

    // Carve need for the current request, in an AB+1 bit space.
    logic [AB:0]   need;
    logic [AB:0]   top_sum;
    logic          carve_ok;
    logic [AB:0]   rounded;
    assign rounded = ({1'b0, AB'(size_reg)} + (AB+1)'(7)) & ~(AB+1)'(7);
    always_comb
    begin
        if (cls_reg == LAST)
            need = (AB+1)'(sfa_pkg::BIG_HEADERS * sfa_pkg::HEADER_BYTES) + rounded;
        else
            need = (AB+1)'(sfa_pkg::HEADER_BYTES)
                 + (AB+1)'(sfa_pkg::class_bytes(int'(cls_reg)));
    end
    assign top_sum  = {1'b0, top_reg} + need;
    // A need past the address space can never fit, whatever the top.
    assign carve_ok = !need[AB] && !top_sum[AB] && (top_sum <= (AB+1)'(limit_reg));

    logic [AB:0] carve_size;
    assign carve_size = need - (AB+1)'(sfa_pkg::HEADER_BYTES);

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign cfg.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload_address = rsp_addr_reg;
    assign rsp.granted_size    = rsp_size_reg;
    assign rsp.status          = rsp_status_reg;

    // Memory port control.
    always_comb
    begin
        mem_rd = 1'b0;
        mem_wr = 1'b0;
        mem_slot = k_reg;
        wr_addr_data = baddr_reg[AB-1:0];
        wr_size_data = size_reg;
        wr_size_en = 1'b0;
        case (state_reg)
            S_DECODE:
            begin
                if (mode_reg && baddr_reg != 32'd0 && n_reg < DEPTH_N)
                begin
                    mem_wr = 1'b1;
                    mem_slot = DB'(n_reg);
                    wr_size_en = (cls_reg == LAST);
                end
                else if (!mode_reg && cls_reg != LAST && n_reg != '0)
                begin
                    mem_rd = 1'b1;
                    mem_slot = DB'(n_reg - NB'(1));
                end
            end
            S_SCAN, S_SHIFT_RD:
                mem_rd = 1'b1;
            S_SHIFT_WR:
            begin
                mem_wr = 1'b1;
                mem_slot = k_reg - DB'(1);
                wr_addr_data = addr_q;
                wr_size_data = size_q;
                wr_size_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            top_reg <= '0;
            limit_reg <= '1;
            for (int i = 0; i < sfa_pkg::CLASS_COUNT; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                // A new heap base restarts the bump pointer there.
                if (cfg.index == sfa_pkg::CFG_HEAP_BASE)
                    top_reg <= AB'(cfg.data);
                else
                    limit_reg <= cfg.data;
            end
            case (state_reg)
                S_IDLE:
                    if (req.valid && req.ready)
                    begin
                        mode_reg <= req.mode;
                        size_reg <= req.request_size;
                        baddr_reg <= req.block_address;
                        cls_reg <= req_cls;
                        n_reg <= count_reg[req_cls];
                        k_reg <= DB'(count_reg[req_cls]);
                        state_reg <= S_DECODE;
                    end
                S_DECODE:
                begin
                    rsp_addr_reg <= '0;
                    rsp_size_reg <= '0;
                    rsp_status_reg <= sfa_pkg::STATUS_OK;
                    if (mode_reg)
                    begin
                        // Free: drop address zero, flag a full class.
                        if (baddr_reg != 32'd0)
                        begin
                            if (n_reg < DEPTH_N)
                                count_reg[cls_reg] <= n_reg + NB'(1);
                            else
                                rsp_status_reg <= sfa_pkg::STATUS_FULL;
                        end
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (cls_reg != LAST && n_reg != '0)
                    begin
                        count_reg[cls_reg] <= n_reg - NB'(1);
                        state_reg <= S_POP;
                    end
                    else if (cls_reg == LAST && n_reg != '0)
                    begin
                        k_reg <= DB'(n_reg - NB'(1));
                        state_reg <= S_SCAN;
                    end
                    else
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    // Carve from the bump pointer.
                    if (carve_ok)
                    begin
                        top_reg <= top_sum[AB-1:0];
                        rsp_addr_reg <= 32'(top_reg + AB'(sfa_pkg::HEADER_BYTES));
                        rsp_size_reg <= (carve_size > (AB+1)'(32'hFFFFFFFF))
                                      ? 32'hFFFFFFFF : 32'(carve_size);
                        rsp_status_reg <= sfa_pkg::STATUS_OK;
                    end
                    else
                    begin
                        rsp_addr_reg <= '0;
                        rsp_size_reg <= '0;
                        rsp_status_reg <= sfa_pkg::STATUS_EXHAUSTED;
                    end
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_POP:
                begin
                    rsp_addr_reg <= 32'(addr_q);
                    rsp_size_reg <= sfa_pkg::class_bytes(int'(cls_reg));
                    rsp_status_reg <= sfa_pkg::STATUS_OK;
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                    state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    if (size_q >= size_reg)
                    begin
                        hit_addr_reg <= addr_q;
                        hit_size_reg <= size_q;
                        count_reg[cls_reg] <= n_reg - NB'(1);
                        if (NB'(k_reg) + NB'(1) < n_reg)
                        begin
                            k_reg <= k_reg + DB'(1);
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            rsp_addr_reg <= 32'(addr_q);
                            rsp_size_reg <= size_q;
                            rsp_status_reg <= sfa_pkg::STATUS_OK;
                            rsp_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (k_reg == '0)
                        state_reg <= S_READ;
                    else
                    begin
                        k_reg <= k_reg - DB'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SHIFT_RD:
                    state_reg <= S_SHIFT_WR;
                S_SHIFT_WR:
                begin
                    // Move entry k down to k-1; advance until the top is closed.
                    if (NB'(k_reg) + NB'(1) < n_reg)
                    begin
                        k_reg <= k_reg + DB'(1);
                        state_reg <= S_SHIFT_RD;
                    end
                    else
                    begin
                        rsp_addr_reg <= 32'(hit_addr_reg);
                        rsp_size_reg <= hit_size_reg;
                        rsp_status_reg <= sfa_pkg::STATUS_OK;
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
